// ----- rtl/core/tbm_pkg.sv -----
// shared types and constants of the token bucket packet meter
`default_nettype none

package tbm_pkg;

  // field widths of the ports
  localparam int unsigned TIME_W     = 63;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PPB_W      = 20;
  localparam int unsigned BKT_W      = 24;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned CFG_IDX_W  = 2;

  // per-byte cost after the quarter and half rate scaling
  localparam int unsigned RATE_W = PPB_W + 2;

  // defaults of the top level parameters
  localparam int unsigned CREDIT_BITS_DEF = 24;
  localparam int unsigned TIME_BITS_DEF   = 63;

  // register reset values
  localparam logic [PPB_W-1:0] PPB_RST = PPB_W'(80);
  localparam logic [BKT_W-1:0] BKT_RST = BKT_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PS_PER_BYTE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BYTES       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_RATE_UNTIL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_RATE_UNTIL    = 2'd3;

  // verdict codes
  localparam logic COLOR_GREEN = 1'b0;
  localparam logic COLOR_RED   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture the accepted word
    logic prep;       // elapsed time and per-byte cost
    logic load_div;   // overflow check and divider setup
    logic div_step;   // one quotient bit
    logic refill;     // add the quotient to the credit
    logic verdict;    // color the packet and charge the credit
  } tbm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;   // the current step produces the last quotient bit
  } tbm_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/tbm_chan_if.sv -----
// valid/ready channel interfaces for packet words and verdict words
`default_nettype none

interface tbm_in_if import tbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [LEN_W-1:0]  packet_bytes;

  modport source (output valid, output arrival_time, output packet_bytes, input ready);
  modport sink   (input valid, input arrival_time, input packet_bytes, output ready);
endinterface

interface tbm_out_if import tbm_pkg::*; ();
  logic valid;
  logic ready;
  logic color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tbm_ctrl.sv -----
// sequencing state machine of the token bucket packet meter
`default_nettype none

module tbm_ctrl import tbm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tbm_sts_t sts_i,
  output tbm_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_LOAD   = 6'b000100,
    S_DIV    = 6'b001000,
    S_REFILL = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_div = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.verdict = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.verdict) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tbm_dp.sv -----
// datapath: registers, refill divider, credit update and verdict
`default_nettype none

module tbm_dp import tbm_pkg::*; #(
  parameter int unsigned CREDIT_BITS = CREDIT_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [TIME_W-1:0]     arrival_time_i,
  input  wire logic [LEN_W-1:0]      packet_bytes_i,
  input  wire tbm_cmd_t              cmd_i,
  output tbm_sts_t                   sts_o,
  output logic                       color_o
);

  localparam int unsigned SHIFT_W = RATE_W + CREDIT_BITS;
  localparam int unsigned CMP_W   = (TIME_BITS > SHIFT_W) ? TIME_BITS : SHIFT_W;
  localparam int unsigned LIM_W   = (CREDIT_BITS > BKT_W) ? CREDIT_BITS : BKT_W;
  localparam int unsigned CHK_W   = (CREDIT_BITS > LEN_W) ? CREDIT_BITS : LEN_W;
  localparam int unsigned CNT_W   = $clog2(CREDIT_BITS);

  localparam logic [LIM_W-1:0] LIM_MASK = LIM_W'({CREDIT_BITS{1'b1}});
  localparam logic [LIM_W-1:0] BKT_RST_EXT = LIM_W'(BKT_RST);
  localparam logic [CREDIT_BITS-1:0] CREDIT_RST =
    CREDIT_BITS'((BKT_RST_EXT > LIM_MASK) ? LIM_MASK : BKT_RST_EXT);

  // configuration
  logic [PPB_W-1:0]      ppb_q;
  logic [BKT_W-1:0]      bkt_q;
  logic [CFG_DATA_W-1:0] quarter_q;
  logic [CFG_DATA_W-1:0] half_q;

  // bucket state
  logic [CREDIT_BITS-1:0] credit_q, credit_d;
  logic [TIME_BITS-1:0]   last_q;

  // per packet work registers
  logic [TIME_BITS-1:0]   now_q;
  logic [LEN_W-1:0]       len_q;
  logic [TIME_BITS-1:0]   elapsed_q;
  logic [RATE_W-1:0]      rate_q;
  logic                   sat_q;
  logic [RATE_W-1:0]      rem_q;
  logic [CREDIT_BITS-1:0] low_q;
  logic [CREDIT_BITS-1:0] quot_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   color_q;

  logic [PPB_W-1:0]       ppb_eff;
  logic [RATE_W-1:0]      rate_d;
  logic [TIME_BITS-1:0]   elapsed_d;
  logic [CMP_W-1:0]       el_ext;
  logic [CMP_W-1:0]       rate_shl;
  logic [RATE_W:0]        trial;
  logic                   qbit;
  logic [LIM_W-1:0]       bkt_ext;
  logic [CREDIT_BITS-1:0] limit;
  logic [CREDIT_BITS:0]   sum;
  logic                   red;

  // per-byte cost, scaled up by four or two in the early windows
  assign ppb_eff = (ppb_q == '0) ? PPB_W'(1) : ppb_q;

  always_comb begin
    if (now_q < quarter_q[TIME_BITS-1:0]) begin
      rate_d = {ppb_eff, 2'b00};
    end else if (now_q < half_q[TIME_BITS-1:0]) begin
      rate_d = {1'b0, ppb_eff, 1'b0};
    end else begin
      rate_d = {2'b00, ppb_eff};
    end
  end

  assign elapsed_d = (now_q > last_q) ? (now_q - last_q) : '0;

  // quotient overflows the credit width when elapsed >= rate * 2^CREDIT_BITS
  assign el_ext   = CMP_W'(elapsed_q);
  assign rate_shl = CMP_W'(rate_q) << CREDIT_BITS;

  // restoring division, one bit per step
  assign trial = {rem_q, low_q[CREDIT_BITS-1]};
  assign qbit  = (trial >= {1'b0, rate_q});

  assign sts_o.div_last = (cnt_q == '0);

  // bucket size capped at the credit width
  assign bkt_ext = LIM_W'(bkt_q);
  assign limit   = CREDIT_BITS'((bkt_ext > LIM_MASK) ? LIM_MASK : bkt_ext);

  assign sum = {1'b0, credit_q} + {1'b0, quot_q};
  assign red = (CHK_W'(len_q) > CHK_W'(credit_q));

  always_comb begin
    credit_d = credit_q;
    if (cmd_i.refill) begin
      if (sat_q || (sum >= {1'b0, limit})) begin
        credit_d = limit;
      end else begin
        credit_d = sum[CREDIT_BITS-1:0];
      end
    end else if (cmd_i.verdict && !red) begin
      credit_d = credit_q - CREDIT_BITS'(len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppb_q     <= PPB_RST;
      bkt_q     <= BKT_RST;
      quarter_q <= '0;
      half_q    <= '0;
      credit_q  <= CREDIT_RST;
      last_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PS_PER_BYTE:        ppb_q     <= cfg_data_i[PPB_W-1:0];
          CFG_BUCKET_BYTES:       bkt_q     <= cfg_data_i[BKT_W-1:0];
          CFG_QUARTER_RATE_UNTIL: quarter_q <= cfg_data_i;
          CFG_HALF_RATE_UNTIL:    half_q    <= cfg_data_i;
          default: ;
        endcase
      end
      credit_q <= credit_d;
      if (cmd_i.prep) begin
        last_q <= now_q;
      end
      if (cmd_i.load_div) begin
        cnt_q <= CNT_W'(CREDIT_BITS - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      now_q <= arrival_time_i[TIME_BITS-1:0];
      len_q <= packet_bytes_i;
    end
    if (cmd_i.prep) begin
      rate_q    <= rate_d;
      elapsed_q <= elapsed_d;
    end
    if (cmd_i.load_div) begin
      sat_q <= (el_ext >= rate_shl);
      rem_q <= RATE_W'(el_ext >> CREDIT_BITS);
      low_q <= el_ext[CREDIT_BITS-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= qbit ? RATE_W'(trial - {1'b0, rate_q}) : trial[RATE_W-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[CREDIT_BITS-2:0], qbit};
    end
    if (cmd_i.verdict) begin
      color_q <= red ? COLOR_RED : COLOR_GREEN;
    end
  end

  assign color_o = color_q;

endmodule

`default_nettype wire

// ----- rtl/core/token_bucket_packet_meter.sv -----
// top level of the single-rate two-color token bucket packet meter
`default_nettype none

// Two-color packet meter. Each packet word carries its arrival time in
// picoseconds and its length in bytes, and yields one verdict word: green
// (0) when the packet fits in the byte credit, which is then charged with
// its length, or red (1), which leaves the credit alone. Before coloring,
// the bucket is refilled by the whole number of bytes the elapsed time buys
// at ps_per_byte (four times the cost before quarter_rate_until, twice
// before half_rate_until), saturating at bucket_bytes; a fractional byte is
// lost and an arrival earlier than the previous one adds nothing. A packet
// goes through these steps from acceptance until the meter is ready for the
// next one: capture, elapsed time and cost, the overflow check, the restoring
// divider at one quotient bit per cycle, refill, and coloring, which waits
// while the previous verdict is still untaken. The verdict sits in an output
// register, so the next packet is taken while it waits. Configuration writes
// are only safe while idle.
module token_bucket_packet_meter import tbm_pkg::*; #(
  parameter int unsigned CREDIT_BITS = CREDIT_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  tbm_in_if.sink                     pkt_i,
  tbm_out_if.source                  vrd_o
);

  tbm_cmd_t cmd;
  tbm_sts_t sts;

  // sequencer: accepts a word, walks the datapath, holds the verdict slot
  tbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_i.valid),
    .in_ready_o  (pkt_i.ready),
    .out_valid_o (vrd_o.valid),
    .out_ready_i (vrd_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // registers, divider and bucket arithmetic
  tbm_dp #(
    .CREDIT_BITS (CREDIT_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .arrival_time_i (pkt_i.arrival_time),
    .packet_bytes_i (pkt_i.packet_bytes),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .color_o        (vrd_o.color)
  );

  // one datapath operation at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.prep, cmd.load_div, cmd.div_step, cmd.refill,
              cmd.verdict}))
    else $error("more than one datapath command at once");

  // a verdict is never written over one still waiting to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.verdict |-> (!vrd_o.valid || vrd_o.ready))
    else $error("verdict overwrites a pending word");

  // no second packet while one is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready) |=> !pkt_i.ready)
    else $error("meter ready again right after an accept");

  // after a refill only coloring comes next, no more division and no new packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.refill |=> !cmd.div_step && !cmd.load_item)
    else $error("refill not followed by coloring");

endmodule

`default_nettype wire

// ----- sim/tb_token_bucket_packet_meter.sv -----
// self-checking testbench of the token bucket packet meter
`timescale 1ns / 100ps

module tb_token_bucket_packet_meter;
  import tbm_pkg::*;

  // run control
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any word moving
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned SETTLE      = 2 * (CREDIT_BITS_DEF + 5);
  localparam logic [TIME_W-1:0] T_MAX = '1;

  typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_e;

  // one row of the directed part: a packet word or a register write
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;    // register index, unused on packet rows
    logic [TIME_W-1:0]    value;  // arrival time or register data
    logic [LEN_W-1:0]     len;
    bit                   known;  // color below is typed in
    logic                 color;
  } dir_row_t;

  typedef enum int unsigned {WIN_NONE, WIN_STAGGER, WIN_ALWAYS} window_e;

  // settings of one random phase
  typedef struct {
    logic [PPB_W-1:0] ppb;
    logic [BKT_W-1:0] bucket;
    window_e          windows;
    bit               calm;     // no idling on either side
    bit               squeeze;  // long receiver hold-off at the start
    int unsigned      n_items;
  } phase_t;

  localparam int unsigned N_DIR   = 27;
  localparam int unsigned N_PHASE = 9;

  // directed walk, starting from reset settings (80 ps per byte, 65536 byte bucket)
  dir_row_t dir_tab [N_DIR] = '{
    // drain the full bucket down to one byte, then to zero
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd0, 16'd65535, 1'b1, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd0, 16'd2, 1'b1, COLOR_RED},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd0, 16'd1, 1'b1, COLOR_GREEN},
    // zero length on an empty bucket
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd0, 16'd0, 1'b1, COLOR_GREEN},
    // 79 ps buys nothing, the fraction is lost
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd79, 16'd1, 1'b1, COLOR_RED},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd159, 16'd1, 1'b1, COLOR_GREEN},
    // latest possible arrival saturates the bucket
    '{ROW_PACKET, CFG_PS_PER_BYTE, T_MAX, 16'd65535, 1'b1, COLOR_GREEN},
    // time going backwards adds nothing but moves the last update
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd100, 16'd1, 1'b1, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd100, 16'd1, 1'b1, COLOR_RED},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd420, 16'd4, 1'b0, COLOR_GREEN},
    // empty bucket size holds the credit at zero
    '{ROW_WRITE, CFG_BUCKET_BYTES, 63'd0, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd1000, 16'd0, 1'b1, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd100000, 16'd1, 1'b1, COLOR_RED},
    // zero cost per byte counts as one ps, largest bucket
    '{ROW_WRITE, CFG_PS_PER_BYTE, 63'd0, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_WRITE, CFG_BUCKET_BYTES, 63'd16777215, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd16877215, 16'd65535, 1'b1, COLOR_GREEN},
    // bucket lowered under the credit, clamped on the next packet
    '{ROW_WRITE, CFG_BUCKET_BYTES, 63'd100, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd16877215, 16'd101, 1'b1, COLOR_RED},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd16877215, 16'd100, 1'b1, COLOR_GREEN},
    // slowest cost, then quarter, half and full rate in turn
    '{ROW_WRITE, CFG_PS_PER_BYTE, 63'd1048575, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_WRITE, CFG_QUARTER_RATE_UNTIL, T_MAX, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_WRITE, CFG_HALF_RATE_UNTIL, T_MAX, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd29460115, 16'd3, 1'b0, COLOR_GREEN},
    '{ROW_WRITE, CFG_QUARTER_RATE_UNTIL, 63'd0, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd39945865, 16'd5, 1'b0, COLOR_GREEN},
    '{ROW_WRITE, CFG_HALF_RATE_UNTIL, 63'd0, 16'd0, 1'b0, COLOR_GREEN},
    '{ROW_PACKET, CFG_PS_PER_BYTE, 63'd47285890, 16'd8, 1'b0, COLOR_GREEN}
  };

  // random phases: reset-like, extremes of cost and size, rate windows
  phase_t phase_tab [N_PHASE] = '{
    '{20'd80, 24'd65536, WIN_NONE, 1'b0, 1'b0, 105},
    '{20'd1, 24'd1500, WIN_STAGGER, 1'b0, 1'b0, 105},
    '{20'd1048575, 24'd16777215, WIN_STAGGER, 1'b0, 1'b1, 105},
    '{20'd0, 24'd9000, WIN_STAGGER, 1'b1, 1'b0, 105},
    '{20'd8, 24'd1, WIN_NONE, 1'b0, 1'b0, 105},
    '{20'd200, 24'd0, WIN_NONE, 1'b0, 1'b0, 40},
    '{20'd33, 24'd200000, WIN_ALWAYS, 1'b0, 1'b0, 105},
    '{20'd800, 24'd4096, WIN_STAGGER, 1'b1, 1'b0, 105},
    '{20'd12345, 24'd65535, WIN_STAGGER, 1'b0, 1'b0, 105}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tbm_in_if  pkt ();
  tbm_out_if vrd ();

  token_bucket_packet_meter u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pkt_i     (pkt),
    .vrd_o     (vrd)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // meter state as the testbench sees it
  logic [PPB_W-1:0]  reg_ppb;
  logic [BKT_W-1:0]  reg_bucket;
  logic [TIME_W-1:0] reg_quarter;
  logic [TIME_W-1:0] reg_half;
  logic [63:0]       cur_credit;
  logic [TIME_W-1:0] prev_arrival;

  // colors still owed by the meter, oldest first
  logic colors_due [$];

  bit          calm;
  bit          hold_req;
  int unsigned errors;
  int unsigned n_packets, n_green, n_red, n_writes, n_backward, n_zero_len, n_holds;
  logic [TIME_W-1:0] next_time;

  // refill by whole bytes, saturate, then color and charge the packet
  function automatic logic meter_packet(input logic [TIME_W-1:0] now,
                                        input logic [LEN_W-1:0] len);
    logic [63:0] cost;
    logic [63:0] elapsed;
    logic [63:0] gain;
    logic [63:0] limit;
    cost  = (reg_ppb == '0) ? 64'd1 : 64'(reg_ppb);
    limit = 64'(reg_bucket);
    // quarter window wins over the half window
    if (now < reg_quarter) cost = cost << 2;
    else if (now < reg_half) cost = cost << 1;
    elapsed = (now > prev_arrival) ? 64'(now - prev_arrival) : 64'd0;
    gain = elapsed / cost;
    // also clamps a credit left above a freshly lowered bucket
    if (gain >= limit || cur_credit + gain >= limit) cur_credit = limit;
    else cur_credit = cur_credit + gain;
    prev_arrival = now;
    if (64'(len) > cur_credit) return COLOR_RED;
    cur_credit = cur_credit - 64'(len);
    return COLOR_GREEN;
  endfunction

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // offer one packet word at the falling edge, hold it until it is taken,
  // then drop valid at the next falling edge
  task automatic send_packet(input logic [TIME_W-1:0] t, input logic [LEN_W-1:0] len,
                             input bit known, input logic typed_color);
    int unsigned gap;
    logic        c;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    pkt.valid        <= 1'b1;
    pkt.arrival_time <= t;
    pkt.packet_bytes <= len;
    do @(posedge clk); while (pkt.ready !== 1'b1);
    c = meter_packet(t, len);
    colors_due.push_back(known ? typed_color : c);
    n_packets++;
    if (c == COLOR_GREEN) n_green++;
    else n_red++;
    if (t < next_time) n_backward++;
    if (len == '0) n_zero_len++;
    next_time = t;
    @(negedge clk);
    pkt.valid <= 1'b0;
  endtask

  // register write, only once every owed verdict is back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    pkt.valid <= 1'b0;
    while (colors_due.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PS_PER_BYTE:        reg_ppb     = val[PPB_W-1:0];
      CFG_BUCKET_BYTES:       reg_bucket  = val[BKT_W-1:0];
      CFG_QUARTER_RATE_UNTIL: reg_quarter = val[TIME_W-1:0];
      CFG_HALF_RATE_UNTIL:    reg_half    = val[TIME_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // one random phase: settings, then a packet train around the refill rate
  task automatic run_phase(input phase_t ph);
    logic [63:0]       cost;
    logic [63:0]       span;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t;
    int unsigned       len_cap;
    int unsigned       pick;
    int unsigned       len;
    cost    = (ph.ppb == '0) ? 64'd1 : 64'(ph.ppb);
    len_cap = (ph.bucket == '0) ? 4 :
              (int'(ph.bucket) / 2 + 1 > 65535) ? 65535 : int'(ph.bucket) / 2 + 1;
    span    = cost * len_cap * ph.n_items;
    t0      = prev_arrival;
    calm    = ph.calm;
    write_reg(CFG_PS_PER_BYTE, CFG_DATA_W'(ph.ppb));
    write_reg(CFG_BUCKET_BYTES, CFG_DATA_W'(ph.bucket));
    case (ph.windows)
      // slow refill over the first quarter, half rate up to the middle
      WIN_STAGGER: begin
        write_reg(CFG_QUARTER_RATE_UNTIL, t0 + TIME_W'(span / 4));
        write_reg(CFG_HALF_RATE_UNTIL, t0 + TIME_W'(span / 2));
      end
      WIN_ALWAYS: begin
        write_reg(CFG_QUARTER_RATE_UNTIL, T_MAX);
        write_reg(CFG_HALF_RATE_UNTIL, T_MAX);
      end
      default: begin
        write_reg(CFG_QUARTER_RATE_UNTIL, '0);
        write_reg(CFG_HALF_RATE_UNTIL, '0);
      end
    endcase
    // the receiver stalls while packets keep coming, so the meter backs up
    if (ph.squeeze) hold_req = 1'b1;
    t = t0;
    repeat (ph.n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) t = t - TIME_W'(64'($urandom_range(0, len_cap)) * cost);
      else if (pick < 7) t = t;
      else if (pick < 9) t = TIME_W'({$urandom, $urandom});
      else t = t + TIME_W'(64'($urandom_range(0, 2 * len_cap)) * cost
                           + 64'($urandom_range(0, int'(cost - 1))));
      pick = $urandom_range(0, 99);
      if (pick < 5) len = 0;
      else if (pick < 10) len = 65535;
      else if (pick < 15) len = (len_cap + 16 > 65535) ? 65535 : len_cap + $urandom_range(0, 15);
      else len = $urandom_range(0, len_cap);
      send_packet(t, LEN_W'(len), 1'b0, COLOR_GREEN);
    end
  endtask

  // verdict checker, oldest expectation first
  always @(posedge clk) begin
    logic want;
    if (rst_n === 1'b1 && vrd.valid === 1'b1 && vrd.ready === 1'b1) begin
      if (colors_due.size() == 0) begin
        errors++;
        $display("%0t: verdict with none owed, expected none, got color %b",
                 $time, vrd.color);
      end else begin
        want = colors_due.pop_front();
        if (vrd.color !== want) begin
          errors++;
          $display("%0t: color mismatch, expected %b, got %b", $time, want, vrd.color);
        end
      end
    end
  end

  // receiver: random hold-offs, and one long one on request
  initial begin
    int unsigned gap;
    vrd.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end else begin
        gap = pick_gap();
      end
      @(negedge clk);
      if (gap != 0) begin
        vrd.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      vrd.ready <= 1'b1;
      do @(posedge clk); while (vrd.valid !== 1'b1);
    end
  end

  // watchdog on cycles in which no word moves on either side
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (pkt.valid === 1'b1 && pkt.ready === 1'b1) ||
        (vrd.valid === 1'b1 && vrd.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence: reset, directed table, random phases, drain
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_PS_PER_BYTE;
    cfg_data         = '0;
    pkt.valid        = 1'b0;
    pkt.arrival_time = '0;
    pkt.packet_bytes = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    next_time        = '0;
    // meter after reset
    reg_ppb      = PPB_RST;
    reg_bucket   = BKT_RST;
    reg_quarter  = '0;
    reg_half     = '0;
    cur_credit   = 64'(BKT_RST);
    prev_arrival = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_WRITE) write_reg(dir_tab[r].idx, dir_tab[r].value);
      else send_packet(dir_tab[r].value, dir_tab[r].len, dir_tab[r].known, dir_tab[r].color);
    end

    foreach (phase_tab[p]) run_phase(phase_tab[p]);

    @(negedge clk);
    pkt.valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    // any stray verdict would show up in this window
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d packets (%0d green, %0d red), %0d register writes, %0d phases",
             n_packets, n_green, n_red, n_writes, N_PHASE);
    $display("summary: %0d backward arrivals, %0d zero-length packets, %0d long hold-offs",
             n_backward, n_zero_len, n_holds);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
